FILE: rtl/core/glos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glos_pkg
// Shared constants, types and cell helpers for the grid line-of-sight block.
// ----------------------------------------------------------------------------
package glos_pkg;

  localparam int GridWidth  = 16;
  localparam int GridHeight = 16;
  localparam int CoordW     = 4;
  localparam int PosW       = CoordW + 2;
  localparam int StepW      = CoordW + 1;
  localparam int ProdW      = StepW + CoordW;
  localparam int Cells      = GridWidth * GridHeight;
  localparam int AddrW      = $clog2(Cells);

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0] map_x;
    logic [CoordW-1:0] map_y;
    logic              wall;
    logic [CoordW-1:0] from_x;
    logic [CoordW-1:0] from_y;
    logic [CoordW-1:0] to_x;
    logic [CoordW-1:0] to_y;
  } glos_req_t;

  typedef struct packed {
    logic load;
    logic write;
    logic adv_x;
    logic adv_y;
    logic rd_side;
  } glos_cmd_t;

  typedef struct packed {
    logic tie;
    logic neg;
    logic at_end;
    logic blk0;
    logic blk1;
  } glos_sts_t;

  function automatic logic in_grid(logic signed [PosW-1:0] x, logic signed [PosW-1:0] y);
    return (x >= 0) && (y >= 0) && (int'(x) < GridWidth) && (int'(y) < GridHeight);
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(logic signed [PosW-1:0] x,
                                                 logic signed [PosW-1:0] y);
    return AddrW'(int'(y) * GridWidth + int'(x));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/glos_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glos_dp
// Datapath: wall map with two registered read ports, walk position and step
// counters, and the step decision.
// ----------------------------------------------------------------------------
module glos_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  glos_pkg::glos_req_t req_i,
  input  glos_pkg::glos_cmd_t cmd_i,
  output glos_pkg::glos_sts_t sts_o
);

  logic                              mem_q [glos_pkg::Cells];
  logic [glos_pkg::Cells-1:0]        vld_q;

  logic signed [glos_pkg::PosW-1:0]  x_q, y_q, xs, ys, xn, yn;
  logic signed [glos_pkg::PosW-1:0]  p0x, p0y, p1x, p1y;
  logic [glos_pkg::CoordW-1:0]       dx_q, dy_q, ix_q, iy_q;
  logic                              sxn_q, syn_q;
  logic [glos_pkg::AddrW-1:0]        a0, a1, waddr;
  logic                              rd0_q, rd1_q;
  logic                              v0_q, v1_q, oob0_q, oob1_q;
  logic [glos_pkg::ProdW-1:0]        prod_a, prod_b;
  logic                              issue;

  assign xs = sxn_q ? x_q - glos_pkg::PosW'(1) : x_q + glos_pkg::PosW'(1);
  assign ys = syn_q ? y_q - glos_pkg::PosW'(1) : y_q + glos_pkg::PosW'(1);
  assign xn = cmd_i.adv_x ? xs : x_q;
  assign yn = cmd_i.adv_y ? ys : y_q;

  always_comb begin
    if (cmd_i.rd_side) begin
      p0x = xs;
      p0y = y_q;
      p1x = x_q;
      p1y = ys;
    end else begin
      p0x = xn;
      p0y = yn;
      p1x = xn;
      p1y = yn;
    end
  end

  assign a0    = glos_pkg::cell_addr(p0x, p0y);
  assign a1    = glos_pkg::cell_addr(p1x, p1y);
  assign waddr = glos_pkg::AddrW'(int'(req_i.map_y) * glos_pkg::GridWidth
                                  + int'(req_i.map_x));
  assign issue = cmd_i.rd_side | cmd_i.adv_x | cmd_i.adv_y;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (int'(req_i.map_x) < glos_pkg::GridWidth)
        && (int'(req_i.map_y) < glos_pkg::GridHeight)) begin
      mem_q[waddr] <= req_i.wall;
    end
    rd0_q <= mem_q[a0];
    rd1_q <= mem_q[a1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      oob0_q <= 1'b0;
      oob1_q <= 1'b0;
    end else begin
      if (cmd_i.write && (int'(req_i.map_x) < glos_pkg::GridWidth)
          && (int'(req_i.map_y) < glos_pkg::GridHeight)) begin
        vld_q[waddr] <= 1'b1;
      end
      if (cmd_i.load) begin
        v0_q   <= 1'b0;
        v1_q   <= 1'b0;
        oob0_q <= 1'b0;
        oob1_q <= 1'b0;
      end else if (issue) begin
        v0_q   <= vld_q[a0];
        v1_q   <= vld_q[a1];
        oob0_q <= !glos_pkg::in_grid(p0x, p0y);
        oob1_q <= !glos_pkg::in_grid(p1x, p1y);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= glos_pkg::PosW'(req_i.from_x);
      y_q   <= glos_pkg::PosW'(req_i.from_y);
      dx_q  <= (req_i.to_x > req_i.from_x) ? req_i.to_x - req_i.from_x
                                           : req_i.from_x - req_i.to_x;
      dy_q  <= (req_i.to_y > req_i.from_y) ? req_i.to_y - req_i.from_y
                                           : req_i.from_y - req_i.to_y;
      sxn_q <= !(req_i.to_x > req_i.from_x);
      syn_q <= !(req_i.to_y > req_i.from_y);
      ix_q  <= '0;
      iy_q  <= '0;
    end else begin
      x_q <= xn;
      y_q <= yn;
      if (cmd_i.adv_x) begin
        ix_q <= ix_q + glos_pkg::CoordW'(1);
      end
      if (cmd_i.adv_y) begin
        iy_q <= iy_q + glos_pkg::CoordW'(1);
      end
    end
  end

  // (1+2ix)*dy against (1+2iy)*dx
  assign prod_a = glos_pkg::ProdW'({ix_q, 1'b1}) * glos_pkg::ProdW'(dy_q);
  assign prod_b = glos_pkg::ProdW'({iy_q, 1'b1}) * glos_pkg::ProdW'(dx_q);

  assign sts_o.tie    = (prod_a == prod_b);
  assign sts_o.neg    = (prod_a < prod_b);
  assign sts_o.at_end = (ix_q == dx_q) && (iy_q == dy_q);
  assign sts_o.blk0   = oob0_q | (v0_q & rd0_q);
  assign sts_o.blk1   = oob1_q | (v1_q & rd1_q);

endmodule
`default_nettype wire

FILE: rtl/core/glos_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glos_ctrl
// Controller: sequences map writes and the cell walk, holds the result
// register.
// ----------------------------------------------------------------------------
module glos_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 req_valid_i,
  output logic                req_ready_o,
  input  wire                 req_mode_i,
  output logic                res_valid_o,
  input  wire                 res_ready_i,
  output logic                res_seen_o,
  output logic                res_query_o,
  output glos_pkg::glos_cmd_t cmd_o,
  input  glos_pkg::glos_sts_t sts_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StSide = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       pend_seen_q, pend_seen_d;
  logic       pend_qry_q, pend_qry_d;
  logic       out_valid_q, out_valid_d;
  logic       out_seen_q, out_seen_d;
  logic       out_qry_q, out_qry_d;

  assign req_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    pend_seen_d = pend_seen_q;
    pend_qry_d  = pend_qry_q;
    out_valid_d = out_valid_q & ~res_ready_i;
    out_seen_d  = out_seen_q;
    out_qry_d   = out_qry_q;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          if (req_mode_i == glos_pkg::ModeQuery) begin
            cmd_o.load = 1'b1;
            pend_qry_d = 1'b1;
            state_d    = StWalk;
          end else begin
            cmd_o.write = 1'b1;
            pend_seen_d = 1'b0;
            pend_qry_d  = 1'b0;
            state_d     = StFin;
          end
        end
      end
      StWalk: begin
        if (sts_i.blk0) begin
          pend_seen_d = 1'b0;
          state_d     = StFin;
        end else if (sts_i.at_end) begin
          pend_seen_d = 1'b1;
          state_d     = StFin;
        end else if (sts_i.tie) begin
          cmd_o.rd_side = 1'b1;
          state_d       = StSide;
        end else if (sts_i.neg) begin
          cmd_o.adv_x = 1'b1;
        end else begin
          cmd_o.adv_y = 1'b1;
        end
      end
      StSide: begin
        if (sts_i.blk0 || sts_i.blk1) begin
          pend_seen_d = 1'b0;
          state_d     = StFin;
        end else begin
          cmd_o.adv_x = 1'b1;
          cmd_o.adv_y = 1'b1;
          state_d     = StWalk;
        end
      end
      StFin: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          out_seen_d  = pend_seen_q;
          out_qry_d   = pend_qry_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_seen_q <= pend_seen_d;
    pend_qry_q  <= pend_qry_d;
    out_seen_q  <= out_seen_d;
    out_qry_q   <= out_qry_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_seen_o  = out_seen_q;
  assign res_query_o = out_qry_q;

endmodule
`default_nettype wire

FILE: rtl/core/grid_line_of_sight.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_line_of_sight
// Wall bitmap of a 16 by 16 grid with a supercover line-of-sight query.
// ----------------------------------------------------------------------------
// channel  dir  tuser       tdata
// s_axis   in   mode        map_x, map_y, wall, from_x, from_y, to_x, to_y
// m_axis   out  was_query   seen
//
// A write goes through the finish state to the result hand-off. A query runs
// load, a walk state per straight step, a side cell check then the step for
// each diagonal tie, a last walk state and the result hand-off.
// Reset clears the map to open at once (one valid flop per cell).
// A new request is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module grid_line_of_sight (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // map_x, map_y, wall, from_x, from_y, to_x, to_y
  input  wire         s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // seen
  output logic        m_axis_tuser    // was_query
);

  glos_pkg::glos_req_t req;
  glos_pkg::glos_cmd_t cmd;
  glos_pkg::glos_sts_t sts;
  logic                seen;

  assign req.map_x  = s_axis_tdata[3:0];
  assign req.map_y  = s_axis_tdata[7:4];
  assign req.wall   = s_axis_tdata[8];
  assign req.from_x = s_axis_tdata[12:9];
  assign req.from_y = s_axis_tdata[16:13];
  assign req.to_x   = s_axis_tdata[20:17];
  assign req.to_y   = s_axis_tdata[24:21];

  glos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_mode_i  (s_axis_tuser),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_seen_o  (seen),
    .res_query_o (m_axis_tuser),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  glos_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  assign m_axis_tdata = {7'b0, seen};

endmodule
`default_nettype wire

FILE: verif/tb_grid_line_of_sight.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_grid_line_of_sight
// Self-checking bench for the grid line-of-sight block. A short table of
// hand-picked requests (empty map, walls on the target, diagonal ties with a
// blocked side cell, straight lines, start equal to target) is followed by
// random writes and queries. Typed rows give their own result; the rest is
// checked against a wall-map model kept here. Both stream sides stall at
// random, the sink once holds off long and the source once drains the block.
// ----------------------------------------------------------------------------
module tb_grid_line_of_sight;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom  = 500;
  localparam int CalmTail   = 60;
  localparam int HoldCycles = 300;
  localparam int DrainWait  = 40;
  localparam int StallLimit = 5000;

  typedef struct {
    bit seen;
    bit was_query;
  } sight_res_t;

  typedef struct {
    logic       mode;
    logic [3:0] map_x;
    logic [3:0] map_y;
    logic       wall;
    logic [3:0] from_x;
    logic [3:0] from_y;
    logic [3:0] to_x;
    logic [3:0] to_y;
    bit         typed;
    bit         typed_seen;
  } req_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;

  bit          wall_bits [glos_pkg::Cells];
  sight_res_t  sight_q [$];
  req_row_t    dir_rows [$];
  int          err_cnt;
  int          n_writes;
  int          n_queries;
  int          n_seen;
  int          n_long_walks;
  bit          calm_phase;
  bit          hold_req;

  grid_line_of_sight uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // outside the grid counts as wall
  function automatic bit cell_shut(input int x, input int y);
    if (x < 0 || y < 0 || x >= glos_pkg::GridWidth || y >= glos_pkg::GridHeight) return 1'b1;
    return wall_bits[y * glos_pkg::GridWidth + x];
  endfunction

  // supercover walk; start cell never tested, target cell is
  function automatic bit sight_clear(input logic [3:0] fx, input logic [3:0] fy,
                                     input logic [3:0] tx, input logic [3:0] ty);
    int x, y, dx, dy, sx, sy, ix, iy, d;
    x  = int'(fx);
    y  = int'(fy);
    dx = (tx > fx) ? int'(tx) - x : x - int'(tx);
    dy = (ty > fy) ? int'(ty) - y : y - int'(ty);
    sx = (tx > fx) ? 1 : -1;
    sy = (ty > fy) ? 1 : -1;
    ix = 0;
    iy = 0;
    while (ix < dx || iy < dy) begin
      d = (1 + 2 * ix) * dy - (1 + 2 * iy) * dx;
      if (d == 0) begin
        if (cell_shut(x + sx, y) || cell_shut(x, y + sy)) return 1'b0;
        x  += sx;
        y  += sy;
        ix++;
        iy++;
      end else if (d < 0) begin
        x += sx;
        ix++;
      end else begin
        y += sy;
        iy++;
      end
      if (cell_shut(x, y)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] pack_req(input req_row_t r);
    return {7'd0, r.to_y, r.to_x, r.from_y, r.from_x, r.wall, r.map_y, r.map_x};
  endfunction

  task automatic add_row(input logic mode, input int mx, input int my, input int w,
                         input int fx, input int fy, input int tx, input int ty,
                         input bit typed, input bit typed_seen);
    req_row_t r;
    r.mode       = mode;
    r.map_x      = 4'(mx);
    r.map_y      = 4'(my);
    r.wall       = 1'(w);
    r.from_x     = 4'(fx);
    r.from_y     = 4'(fy);
    r.to_x       = 4'(tx);
    r.to_y       = 4'(ty);
    r.typed      = typed;
    r.typed_seen = typed_seen;
    dir_rows.push_back(r);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_req(input req_row_t r);
    sight_res_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_req(r);
    s_axis_tuser  <= r.mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (r.mode == glos_pkg::ModeWrite) begin
      wall_bits[int'(r.map_y) * glos_pkg::GridWidth + int'(r.map_x)] = r.wall;
      res.seen      = 1'b0;
      res.was_query = 1'b0;
      n_writes++;
    end else begin
      res.seen      = sight_clear(r.from_x, r.from_y, r.to_x, r.to_y);
      res.was_query = 1'b1;
      n_queries++;
      if (res.seen) n_seen++;
      if (res.seen && (r.from_x > r.to_x ? r.from_x - r.to_x : r.to_x - r.from_x) +
          (r.from_y > r.to_y ? r.from_y - r.to_y : r.to_y - r.from_y) >= 16)
        n_long_walks++;
    end
    if (r.typed) begin
      res.seen      = r.typed_seen;
      res.was_query = (r.mode == glos_pkg::ModeQuery);
    end
    sight_q.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic idle_src(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin : res_check
    sight_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sight_q.size() == 0) begin
        $display("%0t: unexpected result seen=%0b was_query=%0b", $time,
                 m_axis_tdata[0], m_axis_tuser);
        err_cnt++;
      end else begin
        want = sight_q.pop_front();
        if (m_axis_tdata[0] !== want.seen) begin
          $display("%0t: seen mismatch, expected %0b actual %0b", $time,
                   want.seen, m_axis_tdata[0]);
          err_cnt++;
        end
        if (m_axis_tuser !== want.was_query) begin
          $display("%0t: was_query mismatch, expected %0b actual %0b", $time,
                   want.was_query, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin : stall_watch
    int quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results pending", $time,
               quiet, sight_q.size());
      $display("grid_line_of_sight verification failed");
      $finish;
    end
  end

  // sink side
  initial begin : sink_proc
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (calm_phase || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        repeat (calm_phase ? 1 : $urandom_range(1, 30)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
    end
  end

  initial begin : source_proc
    req_row_t r;
    int       wall_pct;
    int       fx, fy;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = glos_pkg::ModeWrite;
    err_cnt       = 0;
    calm_phase    = 1'b0;
    hold_req      = 1'b0;
    foreach (wall_bits[i]) wall_bits[i] = 1'b0;

    add_row(glos_pkg::ModeQuery, 0, 0, 0, 0, 0, 15, 15, 1, 1);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 15, 0, 0, 15, 1, 1);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 7, 7, 7, 7, 1, 1);
    add_row(glos_pkg::ModeWrite, 15, 15, 1, 0, 0, 0, 0, 1, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 0, 0, 15, 15, 1, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 15, 15, 15, 15, 1, 1);
    add_row(glos_pkg::ModeWrite, 0, 0, 1, 0, 0, 0, 0, 1, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 0, 0, 5, 0, 1, 1);
    add_row(glos_pkg::ModeWrite, 1, 0, 1, 0, 0, 0, 0, 1, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 0, 0, 1, 1, 1, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 0, 1, 1, 0, 0, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 0, 0, 0, 15, 1, 1);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 15, 15, 0, 0, 0, 0);
    add_row(glos_pkg::ModeWrite, 8, 8, 1, 0, 0, 0, 0, 1, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 3, 8, 15, 8, 1, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 8, 0, 8, 15, 0, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 5, 3, 12, 9, 0, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 2, 9, 14, 4, 0, 0);
    add_row(glos_pkg::ModeWrite, 15, 15, 0, 0, 0, 0, 0, 1, 0);
    add_row(glos_pkg::ModeWrite, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    add_row(glos_pkg::ModeWrite, 1, 0, 0, 0, 0, 0, 0, 1, 0);
    add_row(glos_pkg::ModeWrite, 8, 8, 0, 0, 0, 0, 0, 1, 0);
    add_row(glos_pkg::ModeQuery, 0, 0, 0, 15, 15, 0, 0, 1, 1);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) begin
      if ($urandom_range(0, 3) == 0) idle_src($urandom_range(1, 19));
      issue_req(dir_rows[k]);
    end

    for (int i = 0; i < NumRandom; i++) begin
      calm_phase = (i >= NumRandom - CalmTail);
      if (i == 150) hold_req = 1'b1;
      if (i == 300) begin
        s_axis_tvalid <= 1'b0;
        while (sight_q.size() != 0) @(negedge clk_i);
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        idle_src($urandom_range(1, 19));
      end
      wall_pct = (i >= 200 && i < 280) ? 45 : 12;
      r.typed  = 1'b0;
      r.typed_seen = 1'b0;
      r.mode   = ($urandom_range(0, 99) < 35) ? glos_pkg::ModeWrite : glos_pkg::ModeQuery;
      r.map_x  = 4'($urandom_range(0, 15));
      r.map_y  = 4'($urandom_range(0, 15));
      r.wall   = ($urandom_range(0, 99) < wall_pct);
      r.from_x = 4'($urandom_range(0, 15));
      r.from_y = 4'($urandom_range(0, 15));
      r.to_x   = 4'($urandom_range(0, 15));
      r.to_y   = 4'($urandom_range(0, 15));
      fx = int'(r.from_x);
      fy = int'(r.from_y);
      case ($urandom_range(0, 3))
        0: begin
          // short hop near the viewer
          r.to_x = 4'($urandom_range(fx < 3 ? 0 : fx - 3, fx > 12 ? 15 : fx + 3));
          r.to_y = 4'($urandom_range(fy < 3 ? 0 : fy - 3, fy > 12 ? 15 : fy + 3));
        end
        1: begin
          // exact diagonal (a tie on every step) where it fits, else straight along x
          fx = $urandom_range(0, 15);
          r.to_x = 4'(fx);
          fy = int'(r.from_x) > fx ? int'(r.from_x) - fx : fx - int'(r.from_x);
          r.to_y = ($urandom_range(0, 1) && int'(r.from_y) >= fy) ?
                   4'(int'(r.from_y) - fy) :
                   (int'(r.from_y) + fy <= 15 ? 4'(int'(r.from_y) + fy) : r.from_y);
        end
        default: ;
      endcase
      issue_req(r);
    end

    s_axis_tvalid <= 1'b0;
    while (sight_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    $display("Covered %0d map writes and %0d line-of-sight queries", n_writes, n_queries);
    $display("%0d queries visible, %0d of them long walks, %0d blocked",
             n_seen, n_long_walks, n_queries - n_seen);
    if (err_cnt == 0) begin
      $display("grid_line_of_sight verification clean");
    end else begin
      $display("grid_line_of_sight verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
